@@ sv/breath_pressure_alarm_monitor_core_macros.svh @@
// ---------------------------------------------------------------------------
// Breath pressure alarm monitor - assertion macros
// Clocked property helpers used by the top level for its assertions.
// ---------------------------------------------------------------------------
`ifndef BREATH_PRESSURE_ALARM_MONITOR_CORE_MACROS_SVH
`define BREATH_PRESSURE_ALARM_MONITOR_CORE_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define BPAM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define BPAM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `BPAM_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

@@ sv/bpam_pkg.sv @@
// ---------------------------------------------------------------------------
// Breath pressure alarm monitor - package
// Shared constants, register indexes, alarm codes, structs and helpers.
// ---------------------------------------------------------------------------
package bpam_pkg;

  localparam int TRACK_FRACTION_BITS = 16;
  localparam int Q78_SHIFT           = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NO_CYCLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT= 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SWING = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 3'd6;

  // Register reset values
  localparam logic [15:0]        ATTACK_RST     = 16'd59299;
  localparam logic [15:0]        RELEASE_RST    = 16'd65492;
  localparam logic [15:0]        NO_CYCLE_RST   = 16'd1000;
  localparam logic signed [15:0] LOW_LIMIT_RST  = 16'sd512;
  localparam logic signed [15:0] HIGH_LIMIT_RST = 16'sd10240;
  localparam logic [15:0]        MIN_SWING_RST  = 16'd768;
  localparam logic [15:0]        HOLDOFF_RST    = 16'd500;

  // Display and last-sample reset values, Q7.8 (25 and 10 cm H2O)
  localparam logic signed [15:0] PEAK_SHOWN_RST   = 16'sd6400;
  localparam logic signed [15:0] TROUGH_SHOWN_RST = 16'sd2560;
  localparam int                 TROUGH_TRACK_CM  = 100;

  typedef enum logic [1:0] {
    ALARM_CLEAR    = 2'd0,
    ALARM_NO_CYCLE = 2'd1,
    ALARM_LOW      = 2'd2,
    ALARM_HIGH     = 2'd3
  } alarm_e;

  typedef struct packed {
    logic [15:0]        attack;
    logic [15:0]        rel_coef;
    logic [15:0]        no_cycle_limit;
    logic signed [15:0] low_limit;
    logic signed [15:0] high_limit;
    logic [15:0]        min_swing;
    logic [15:0]        holdoff;
  } cfg_t;

  // Tracker stage state seen by the alarm stage
  typedef struct packed {
    logic signed [31:0] peak_track;
    logic signed [31:0] trough_track;
    logic [15:0]        since_peak;
    logic [15:0]        since_trough;
    logic signed [15:0] peak_shown;
    logic signed [15:0] trough_shown;
    logic               inhaling;
    logic               breath_done;
    logic [15:0]        breath_len;
  } track_t;

  typedef struct packed {
    alarm_e             alarm_kind;
    logic signed [15:0] alarm_level;
    logic signed [15:0] peak_display;
    logic signed [15:0] trough_display;
    logic               inhaling;
    logic               breath_done;
    logic [15:0]        breath_period;
  } res_t;

  function automatic logic [15:0] inc_sat(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // floor((shown + sample + 1) / 2)
  function automatic logic signed [15:0] smooth(input logic signed [15:0] shown,
                                                input logic signed [15:0] sample);
    logic signed [16:0] sum;
    sum = 17'(shown) + 17'(sample) + 17'sd1;
    return 16'(sum >>> 1);
  endfunction

endpackage

@@ sv/bpam_if.sv @@
// ---------------------------------------------------------------------------
// Breath pressure alarm monitor - channel interfaces
// Valid/ready channels for pressure samples and monitor results.
// ---------------------------------------------------------------------------
interface bpam_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pressure;

  modport source (output valid, output pressure, input ready);
  modport sink   (input valid, input pressure, output ready);
endinterface

interface bpam_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         alarm_kind;
  logic signed [15:0] alarm_level;
  logic signed [15:0] peak_display;
  logic signed [15:0] trough_display;
  logic               inhaling;
  logic               breath_done;
  logic [15:0]        breath_period;

  modport source (output valid, output alarm_kind, output alarm_level,
                  output peak_display, output trough_display, output inhaling,
                  output breath_done, output breath_period, input ready);
  modport sink   (input valid, input alarm_kind, input alarm_level,
                  input peak_display, input trough_display, input inhaling,
                  input breath_done, input breath_period, output ready);
endinterface

@@ sv/bpam_tracker.sv @@
// ---------------------------------------------------------------------------
// Breath pressure alarm monitor - tracker stage
// Peak/trough attack-release trackers, phase detection, display smoothing.
// ---------------------------------------------------------------------------
module bpam_tracker #(
  parameter int TRACK_FRACTION_BITS = bpam_pkg::TRACK_FRACTION_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic signed [15:0]    pressure_i,
  input  bpam_pkg::cfg_t        cfg_i,
  output bpam_pkg::track_t      track_o
);

  localparam int SCALE  = TRACK_FRACTION_BITS - bpam_pkg::Q78_SHIFT;
  localparam int PROD_W = 50;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [31:0] TROUGH_RST =
    32'(longint'(bpam_pkg::TROUGH_TRACK_CM) << TRACK_FRACTION_BITS);
  localparam logic signed [31:0] TRACK_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] TRACK_MIN = 32'sh8000_0000;

  // new = floor((old*c + x*(65536-c) + 32768) / 65536), clamped to 32 bits
  function automatic logic signed [31:0] blend(input logic signed [31:0] old,
                                               input logic signed [31:0] x,
                                               input logic [15:0]        c);
    logic signed [16:0]       c_old;
    logic signed [17:0]       c_new;
    logic signed [PROD_W-1:0] p_old;
    logic signed [PROD_W-1:0] p_new;
    logic signed [SUM_W-1:0]  num;
    logic signed [SUM_W-1:0]  shr;
    c_old = $signed({1'b0, c});
    c_new = $signed({1'b0, 17'h1_0000 - {1'b0, c}});
    p_old = old * c_old;
    p_new = x * c_new;
    num   = SUM_W'(p_old) + SUM_W'(p_new) + SUM_W'(32768);
    shr   = num >>> 16;
    if (shr[SUM_W-1:31] != {(SUM_W-31){shr[SUM_W-1]}}) begin
      return shr[SUM_W-1] ? TRACK_MIN : TRACK_MAX;
    end
    return $signed(shr[31:0]);
  endfunction

  logic signed [31:0] peak_q, peak_d, trough_q, trough_d;
  logic [15:0]        since_peak_q, since_peak_d, since_trough_q, since_trough_d;
  logic [15:0]        since_breath_q, since_breath_d, breath_len_q, breath_len_d;
  logic signed [15:0] last_peak_q, last_peak_d, last_trough_q, last_trough_d;
  logic signed [15:0] peak_shown_q, peak_shown_d, trough_shown_q, trough_shown_d;
  logic               inhale_q, inhale_d, done_q, done_d;

  logic signed [31:0] x;
  logic [15:0]        breath_inc, len;
  logic               peak_up, trough_dn, inhale_mid;

  always_comb begin
    x          = 32'(pressure_i) <<< SCALE;
    breath_inc = bpam_pkg::inc_sat(since_breath_q);
    peak_up    = x > peak_q;
    trough_dn  = x < trough_q;

    peak_d         = blend(peak_q, x, peak_up ? cfg_i.attack : cfg_i.rel_coef);
    since_peak_d   = peak_up ? 16'd0 : bpam_pkg::inc_sat(since_peak_q);
    last_peak_d    = peak_up ? pressure_i : last_peak_q;
    trough_shown_d = trough_shown_q;
    inhale_mid     = inhale_q;
    if (peak_up && !inhale_q) begin
      inhale_mid     = 1'b1;
      trough_shown_d = bpam_pkg::smooth(trough_shown_q, last_trough_q);
    end

    trough_d       = blend(trough_q, x, trough_dn ? cfg_i.attack : cfg_i.rel_coef);
    since_trough_d = trough_dn ? 16'd0 : bpam_pkg::inc_sat(since_trough_q);
    last_trough_d  = trough_dn ? pressure_i : last_trough_q;

    len            = (breath_inc > since_peak_d) ? breath_inc - since_peak_d : 16'd0;
    inhale_d       = inhale_mid;
    peak_shown_d   = peak_shown_q;
    since_breath_d = breath_inc;
    breath_len_d   = breath_len_q;
    done_d         = 1'b0;
    // Trough attack while inhaling closes the breath
    if (trough_dn && inhale_mid && breath_inc > 16'd1) begin
      inhale_d       = 1'b0;
      peak_shown_d   = bpam_pkg::smooth(peak_shown_q, last_peak_d);
      since_breath_d = since_peak_d;
      breath_len_d   = (len > cfg_i.no_cycle_limit) ? cfg_i.no_cycle_limit : len;
      done_d         = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q         <= '0;
      trough_q       <= TROUGH_RST;
      since_peak_q   <= '0;
      since_trough_q <= '0;
      since_breath_q <= '0;
      breath_len_q   <= '0;
      last_peak_q    <= bpam_pkg::PEAK_SHOWN_RST;
      last_trough_q  <= bpam_pkg::TROUGH_SHOWN_RST;
      peak_shown_q   <= bpam_pkg::PEAK_SHOWN_RST;
      trough_shown_q <= bpam_pkg::TROUGH_SHOWN_RST;
      inhale_q       <= 1'b0;
      done_q         <= 1'b0;
    end else if (fire_i) begin
      peak_q         <= peak_d;
      trough_q       <= trough_d;
      since_peak_q   <= since_peak_d;
      since_trough_q <= since_trough_d;
      since_breath_q <= since_breath_d;
      breath_len_q   <= breath_len_d;
      last_peak_q    <= last_peak_d;
      last_trough_q  <= last_trough_d;
      peak_shown_q   <= peak_shown_d;
      trough_shown_q <= trough_shown_d;
      inhale_q       <= inhale_d;
      done_q         <= done_d;
    end
  end

  assign track_o = '{
    peak_track:   peak_q,
    trough_track: trough_q,
    since_peak:   since_peak_q,
    since_trough: since_trough_q,
    peak_shown:   peak_shown_q,
    trough_shown: trough_shown_q,
    inhaling:     inhale_q,
    breath_done:  done_q,
    breath_len:   breath_len_q
  };

endmodule

@@ sv/bpam_alarm.sv @@
// ---------------------------------------------------------------------------
// Breath pressure alarm monitor - alarm stage
// Startup holdoff, prioritised alarm latch and the result register.
// ---------------------------------------------------------------------------
module bpam_alarm #(
  parameter int TRACK_FRACTION_BITS = bpam_pkg::TRACK_FRACTION_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  bpam_pkg::track_t track_i,
  input  bpam_pkg::cfg_t   cfg_i,
  output bpam_pkg::res_t   res_o
);

  localparam int SCALE = TRACK_FRACTION_BITS - bpam_pkg::Q78_SHIFT;

  function automatic logic signed [15:0] to_q78(input logic signed [31:0] t);
    logic signed [31:0] sh;
    sh = t >>> SCALE;
    if (sh[31:15] != {17{sh[31]}}) begin
      return sh[31] ? 16'sh8000 : 16'sh7FFF;
    end
    return $signed(sh[15:0]);
  endfunction

  bpam_pkg::alarm_e   kind_q, kind_d;
  logic signed [15:0] level_q, level_d;
  logic               on_q, on_d;
  logic [15:0]        holdoff_q, holdoff_d;

  logic signed [15:0] peak_disp_q, trough_disp_q;
  logic               inhaling_q, done_q;
  logic [15:0]        period_q;

  logic signed [34:0] pk2, tr3;
  logic signed [33:0] swing, swing_min;
  logic signed [31:0] low_lim, high_lim;
  logic               ratio_bad, swing_bad, stall, no_cycle;

  always_comb begin
    pk2       = 35'(track_i.peak_track) <<< 1;
    tr3       = 35'(track_i.trough_track) + (35'(track_i.trough_track) <<< 1);
    swing     = 34'(track_i.peak_track) - 34'(track_i.trough_track);
    swing_min = $signed({2'b00, 32'(cfg_i.min_swing) << SCALE});
    low_lim   = 32'(cfg_i.low_limit) <<< SCALE;
    high_lim  = 32'(cfg_i.high_limit) <<< SCALE;

    ratio_bad = (track_i.trough_track > 32'sd0) && (pk2 < tr3);
    swing_bad = swing < swing_min;
    stall     = (track_i.since_peak > cfg_i.no_cycle_limit) ||
                (track_i.since_trough > cfg_i.no_cycle_limit);
    no_cycle  = stall || ratio_bad || swing_bad;

    kind_d    = kind_q;
    level_d   = level_q;
    on_d      = on_q;
    holdoff_d = holdoff_q;
    if (on_q) begin
      if (no_cycle) begin
        kind_d  = bpam_pkg::ALARM_NO_CYCLE;
        level_d = '0;
      end else if (track_i.trough_track < low_lim) begin
        kind_d  = bpam_pkg::ALARM_LOW;
        level_d = to_q78(track_i.trough_track);
      end else if (track_i.peak_track > high_lim) begin
        kind_d  = bpam_pkg::ALARM_HIGH;
        level_d = to_q78(track_i.peak_track);
      end
    end else if (holdoff_q > cfg_i.holdoff) begin
      on_d      = 1'b1;
      holdoff_d = '0;
    end else begin
      holdoff_d = bpam_pkg::inc_sat(holdoff_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= bpam_pkg::ALARM_CLEAR;
      level_q   <= '0;
      on_q      <= 1'b0;
      holdoff_q <= '0;
    end else if (fire_i) begin
      kind_q    <= kind_d;
      level_q   <= level_d;
      on_q      <= on_d;
      holdoff_q <= holdoff_d;
    end
  end

  // Result payload copy, no reset
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      peak_disp_q   <= track_i.peak_shown;
      trough_disp_q <= track_i.trough_shown;
      inhaling_q    <= track_i.inhaling;
      done_q        <= track_i.breath_done;
      period_q      <= track_i.breath_len;
    end
  end

  assign res_o = '{
    alarm_kind:     kind_q,
    alarm_level:    level_q,
    peak_display:   peak_disp_q,
    trough_display: trough_disp_q,
    inhaling:       inhaling_q,
    breath_done:    done_q,
    breath_period:  period_q
  };

endmodule

@@ sv/breath_pressure_alarm_monitor_core.sv @@
// ---------------------------------------------------------------------------
// Breath pressure alarm monitor - top level
// Airway pressure monitor with breath detection and latched alarms.
// ---------------------------------------------------------------------------
// Usage:
//   sample_i carries one signed Q7.8 pressure sample per transfer; result_o
//   returns exactly one result per sample, in order. Configuration is a
//   plain write port (cfg_we_i, cfg_idx_i, cfg_data_i), written while idle.
//   Pipeline: input register, tracker stage (two attack/release blends,
//   four multipliers), alarm stage feeding the result register.
//   Throughput: one sample per cycle while result_o is not stalled; the
//   tracker state feedback closes within the single tracker stage, the
//   alarm latch within the alarm stage.
//   Stall: each stage advances when the one after it is empty or moving,
//   so up to three samples are held while result_o is stalled, and
//   sample_i.ready drops only when all three stages are full.
//   Reset: trackers, counters, displays and the alarm latch go to their
//   start values, configuration to its defaults; alarms stay off for the
//   holdoff period counted in accepted samples.
// ---------------------------------------------------------------------------
`include "breath_pressure_alarm_monitor_core_macros.svh"

module breath_pressure_alarm_monitor_core #(
  parameter int TRACK_FRACTION_BITS = bpam_pkg::TRACK_FRACTION_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bpam_sample_if.sink                       sample_i,
  bpam_result_if.source                     result_o,
  input  logic                              cfg_we_i,
  input  logic [bpam_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bpam_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  bpam_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack         <= bpam_pkg::ATTACK_RST;
      cfg_q.rel_coef       <= bpam_pkg::RELEASE_RST;
      cfg_q.no_cycle_limit <= bpam_pkg::NO_CYCLE_RST;
      cfg_q.low_limit      <= bpam_pkg::LOW_LIMIT_RST;
      cfg_q.high_limit     <= bpam_pkg::HIGH_LIMIT_RST;
      cfg_q.min_swing      <= bpam_pkg::MIN_SWING_RST;
      cfg_q.holdoff        <= bpam_pkg::HOLDOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpam_pkg::REG_ATTACK:     cfg_q.attack         <= cfg_data_i;
        bpam_pkg::REG_RELEASE:    cfg_q.rel_coef       <= cfg_data_i;
        bpam_pkg::REG_NO_CYCLE:   cfg_q.no_cycle_limit <= cfg_data_i;
        bpam_pkg::REG_LOW_LIMIT:  cfg_q.low_limit      <= $signed(cfg_data_i);
        bpam_pkg::REG_HIGH_LIMIT: cfg_q.high_limit     <= $signed(cfg_data_i);
        bpam_pkg::REG_MIN_SWING:  cfg_q.min_swing      <= cfg_data_i;
        bpam_pkg::REG_HOLDOFF:    cfg_q.holdoff        <= cfg_data_i;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Stage handshake: each stage moves when the next is free or moving
  // -------------------------------------------------------------------------
  logic               in_vld_q, trk_vld_q, out_vld_q;
  logic               en_in, en_trk, en_out;
  logic               fire_trk, fire_out;
  logic signed [15:0] pressure_q;

  assign en_out   = !out_vld_q || result_o.ready;
  assign en_trk   = !trk_vld_q || en_out;
  assign en_in    = !in_vld_q  || en_trk;
  assign fire_trk = in_vld_q  && en_trk;
  assign fire_out = trk_vld_q && en_out;

  assign sample_i.ready = en_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      trk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en_in)  in_vld_q  <= sample_i.valid;
      if (en_trk) trk_vld_q <= in_vld_q;
      if (en_out) out_vld_q <= trk_vld_q;
    end
  end

  // Input sample register
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && en_in) begin
      pressure_q <= sample_i.pressure;
    end
  end

  // -------------------------------------------------------------------------
  // Datapath
  // -------------------------------------------------------------------------
  bpam_pkg::track_t track;
  bpam_pkg::res_t   res;

  bpam_tracker #(
    .TRACK_FRACTION_BITS (TRACK_FRACTION_BITS)
  ) u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire_trk),
    .pressure_i (pressure_q),
    .cfg_i      (cfg_q),
    .track_o    (track)
  );

  bpam_alarm #(
    .TRACK_FRACTION_BITS (TRACK_FRACTION_BITS)
  ) u_alarm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire_out),
    .track_i (track),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  assign result_o.valid          = out_vld_q;
  assign result_o.alarm_kind     = res.alarm_kind;
  assign result_o.alarm_level    = res.alarm_level;
  assign result_o.peak_display   = res.peak_display;
  assign result_o.trough_display = res.trough_display;
  assign result_o.inhaling       = res.inhaling;
  assign result_o.breath_done    = res.breath_done;
  assign result_o.breath_period  = res.breath_period;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // A completed breath always leaves the phase at exhalation
  `BPAM_ASSERT_NEVER(a_done_exhale, clk_i, rst_ni,
    result_o.valid && result_o.breath_done && result_o.inhaling,
    "breath_done with inhaling set")

  // Once latched, an alarm never goes back to none
  `BPAM_ASSERT(a_latch_sticky, clk_i, rst_ni,
    (res.alarm_kind != bpam_pkg::ALARM_CLEAR) |=> (res.alarm_kind != bpam_pkg::ALARM_CLEAR),
    "alarm latch returned to none")

  // Non-cycling and no alarm report a zero level
  `BPAM_ASSERT(a_level_zero, clk_i, rst_ni,
    (res.alarm_kind == bpam_pkg::ALARM_CLEAR || res.alarm_kind == bpam_pkg::ALARM_NO_CYCLE)
      |-> (res.alarm_level == 16'sd0),
    "non-zero level without pressure alarm")

  // A full pipeline under output stall must refuse new samples
  `BPAM_ASSERT_NEVER(a_full_stall, clk_i, rst_ni,
    in_vld_q && trk_vld_q && out_vld_q && !result_o.ready && sample_i.ready,
    "sample accepted with pipeline full and stalled")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Breath pressure alarm monitor - testbench
// Streams airway pressure samples through the monitor and checks every
// result against a cycle-free model of the trackers, breath detector and
// alarm latch, across several register settings and random handshake gaps.
// ---------------------------------------------------------------------------
module testbench;
  import bpam_pkg::*;

  localparam int     RESET_CYCLES = 12;
  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     SETTLE_GAP   = 4;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     FLAT_RUN     = 40;      // flat stretch before the breaths
  localparam int     Q78_ONE      = 256;     // 1 cm H2O in Q7.8
  localparam int     SAT_MAX      = 65535;
  localparam longint SCALE        = longint'(1) << (TRACK_FRACTION_BITS - Q78_SHIFT);
  localparam longint TRACK_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam longint TRACK_MIN    = -TRACK_MAX - 1;

  // Index past the register map; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bpam_sample_if smp ();
  bpam_result_if res ();

  breath_pressure_alarm_monitor_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (smp),
    .result_o   (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // Shared testbench state
  // ------------------------------------------------------------------------
  logic signed [15:0] sample_queue [$];   // samples waiting for the driver
  res_t               monitor_outlook [$]; // predicted results, oldest first
  int                 mismatches;
  int                 cycle_count;
  bit                 quiet;               // no idling on either side

  // Register shadow, held at full int width (limits sign-extended)
  int coef_attack, coef_release, stall_limit, low_lim, high_lim, swing_min;
  int holdoff_len;

  // Monitor state, tracker format is Q.16 cm H2O
  int                 pk_trk, tr_trk;
  int                 since_pk, since_tr, since_br, br_len, hold_cnt;
  int                 last_pk, last_tr, pk_disp, tr_disp;
  bit                 inhale, armed;
  alarm_e             latch_kind;
  logic signed [15:0] latch_lvl;

  // Directed opening: rails, sign boundaries, a first sample that is both
  // a peak and a trough attack before a breath may end, then a short,
  // regular breath.
  logic signed [15:0] opening_seq [$] = '{
    16'sd2560, 16'sh7FFF, -16'sd32768, 16'sd0, -16'sd1, 16'sd1,
    16'sh7FFF, 16'sh7FFF, -16'sd32768, 16'sh5555, -16'sd21846,
    16'sd1280, 16'sd2560, 16'sd5120, 16'sd6400, 16'sd5120, 16'sd2560,
    16'sd1280, 16'sd640, 16'sd1280, 16'sd3840, 16'sd6400, 16'sd256,
    -16'sd256, 16'sd0
  };

  // ------------------------------------------------------------------------
  // Arithmetic helpers for the monitor model
  // ------------------------------------------------------------------------

  // First-order blend, coef is the weight kept on the old value (Q0.16)
  function automatic int mix_track(input int old, input longint target, input int coef);
    longint acc;
    acc = longint'(old) * coef + target * (65536 - coef) + 32768;
    acc = acc >>> 16;
    if (acc > TRACK_MAX) acc = TRACK_MAX;
    if (acc < TRACK_MIN) acc = TRACK_MIN;
    return int'(acc);
  endfunction

  function automatic logic signed [15:0] to_display(input int trk);
    int q;
    q = trk >>> (TRACK_FRACTION_BITS - Q78_SHIFT);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic int half_mix(input int shown, input int fresh);
    return (shown + fresh + 1) >>> 1;
  endfunction

  function automatic int bump(input int v);
    return (v < SAT_MAX) ? v + 1 : SAT_MAX;
  endfunction

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // One sample through the monitor: trackers, phase, breath end, alarms.
  function automatic res_t monitor_step(input logic signed [15:0] p);
    longint x;
    int     span;
    bit     ended;
    res_t   r;
    x     = longint'(p) * SCALE;
    ended = 1'b0;
    since_br = bump(since_br);

    // Peak tracker; a rise above it while exhaling starts inhalation
    if (x > pk_trk) begin
      pk_trk   = mix_track(pk_trk, x, coef_attack);
      since_pk = 0;
      last_pk  = p;
      if (!inhale) begin
        inhale  = 1'b1;
        tr_disp = half_mix(tr_disp, last_tr);
      end
    end else begin
      pk_trk   = mix_track(pk_trk, x, coef_release);
      since_pk = bump(since_pk);
    end

    // Trough tracker; a fall below it while inhaling closes the breath,
    // but never on the sample straight after the previous one
    if (x < tr_trk) begin
      tr_trk   = mix_track(tr_trk, x, coef_attack);
      since_tr = 0;
      last_tr  = p;
      if (inhale && since_br > 1) begin
        inhale   = 1'b0;
        pk_disp  = half_mix(pk_disp, last_pk);
        span     = (since_br > since_pk) ? since_br - since_pk : 0;
        since_br = since_pk;
        br_len   = (span > stall_limit) ? stall_limit : span;
        ended    = 1'b1;
      end
    end else begin
      tr_trk   = mix_track(tr_trk, x, coef_release);
      since_tr = bump(since_tr);
    end

    // Alarm latch in priority order; no condition keeps the old alarm
    if (armed) begin
      if (since_pk > stall_limit || since_tr > stall_limit ||
          (tr_trk > 0 && 2 * longint'(pk_trk) < 3 * longint'(tr_trk)) ||
          longint'(pk_trk) - tr_trk < longint'(swing_min) * SCALE) begin
        latch_kind = ALARM_NO_CYCLE;
        latch_lvl  = '0;
      end else if (longint'(tr_trk) < longint'(low_lim) * SCALE) begin
        latch_kind = ALARM_LOW;
        latch_lvl  = to_display(tr_trk);
      end else if (longint'(pk_trk) > longint'(high_lim) * SCALE) begin
        latch_kind = ALARM_HIGH;
        latch_lvl  = to_display(pk_trk);
      end
    end else if (hold_cnt > holdoff_len) begin
      armed    = 1'b1;
      hold_cnt = 0;
    end else begin
      hold_cnt = bump(hold_cnt);
    end

    r.alarm_kind     = latch_kind;
    r.alarm_level    = latch_lvl;
    r.peak_display   = 16'(pk_disp);
    r.trough_display = 16'(tr_disp);
    r.inhaling       = inhale;
    r.breath_done    = ended;
    r.breath_period  = 16'(br_len);
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // Handshake idling: mostly none, some short, a few long
  // ------------------------------------------------------------------------
  function automatic int idle_span();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // ------------------------------------------------------------------------
  // Sample driver: launches queued samples, predicts at each transfer
  // ------------------------------------------------------------------------
  int gap_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp.valid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (smp.valid && smp.ready)
        monitor_outlook.push_back(monitor_step(smp.pressure));
      if (!smp.valid || smp.ready) begin
        if (gap_left > 0) begin
          smp.valid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (sample_queue.size() > 0) begin
          smp.valid    <= 1'b1;
          smp.pressure <= sample_queue.pop_front();
          gap_left     <= idle_span();
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result monitor: compares each transfer with the oldest prediction
  // ------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%04h, actual 0x%04h",
               $time, field, want, got);
      mismatches++;
    end
  endtask

  int stall_left;

  always @(posedge clk_i) begin : result_check
    res_t want;
    int   span;
    if (!rst_ni) begin
      res.ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (monitor_outlook.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual alarm_kind 0x%0h",
                   $time, res.alarm_kind);
          mismatches++;
        end else begin
          want = monitor_outlook.pop_front();
          check_field("alarm_kind",     want.alarm_kind,     res.alarm_kind);
          check_field("alarm_level",    want.alarm_level,    res.alarm_level);
          check_field("peak_display",   want.peak_display,   res.peak_display);
          check_field("trough_display", want.trough_display, res.trough_display);
          check_field("inhaling",       want.inhaling,       res.inhaling);
          check_field("breath_done",    want.breath_done,    res.breath_done);
          check_field("breath_period",  want.breath_period,  res.breath_period);
        end
      end
      if (stall_left > 0) begin
        res.ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        span = ($urandom_range(0, 3) == 0) ? idle_span() : 0;
        res.ready  <= (span == 0);
        stall_left <= (span > 0) ? span - 1 : 0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Configuration writes, only ever issued with the pipe empty
  // ------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic signed [15:0] v16;
    v16 = value[15:0];
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[15:0];
    case (idx)
      REG_ATTACK:     coef_attack  = int'(value[15:0]);
      REG_RELEASE:    coef_release = int'(value[15:0]);
      REG_NO_CYCLE:   stall_limit  = int'(value[15:0]);
      REG_LOW_LIMIT:  low_lim      = v16;
      REG_HIGH_LIMIT: high_lim     = v16;
      REG_MIN_SWING:  swing_min    = int'(value[15:0]);
      REG_HOLDOFF:    holdoff_len  = int'(value[15:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Whole register set, back to back, plus a stray write past the map
  task automatic apply_setup(input int att, input int rel, input int ncl,
                             input int lo, input int hi, input int swing,
                             input int hold);
    write_reg(REG_ATTACK, att);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_NO_CYCLE, ncl);
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_HIGH_LIMIT, hi);
    write_reg(REG_MIN_SWING, swing);
    write_reg(REG_HOLDOFF, hold);
    write_reg(REG_SPARE, $urandom_range(0, 65535));
    cfg_we_i <= 1'b0;
  endtask

  // Hold the sender until every predicted result has been seen; looked at
  // on the falling edge so the driver's updates have settled
  task automatic settle_idle();
    while (sample_queue.size() != 0 || smp.valid || monitor_outlook.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------------------
  // Random stimulus: mostly ramped breaths with random levels and lengths,
  // some plateaus and some full-range noise
  // ------------------------------------------------------------------------
  task automatic queue_breathing(input int count, input int noise_pct);
    int added, lo, hi, up, down, n, roll;
    added = 0;
    while (added < count) begin
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
        n = $urandom_range(1, 8);
        repeat (n) sample_queue.push_back(16'($urandom));
        added += n;
      end else if (roll < noise_pct + 8) begin
        n  = $urandom_range(2, 30);
        lo = int'($urandom_range(0, 20 * Q78_ONE)) - 5 * Q78_ONE;
        repeat (n) sample_queue.push_back(clip16(lo));
        added += n;
      end else begin
        lo   = int'($urandom_range(0, 15 * Q78_ONE)) - 3 * Q78_ONE;
        hi   = lo + int'($urandom_range(2 * Q78_ONE, 40 * Q78_ONE));
        up   = $urandom_range(1, 12);
        down = $urandom_range(1, 24);
        for (int i = 1; i <= up; i++)
          sample_queue.push_back(clip16(lo + (hi - lo) * i / up +
                                        int'($urandom_range(0, 64)) - 32));
        for (int i = 1; i <= down; i++)
          sample_queue.push_back(clip16(hi - (hi - lo) * i / down +
                                        int'($urandom_range(0, 64)) - 32));
        added += up + down;
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Sequence of phases
  // ------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    smp.valid    = 1'b0;
    smp.pressure = '0;
    res.ready    = 1'b0;
    quiet        = 1'b0;
    mismatches   = 0;

    // Model out of reset
    coef_attack  = ATTACK_RST;
    coef_release = RELEASE_RST;
    stall_limit  = NO_CYCLE_RST;
    low_lim      = LOW_LIMIT_RST;
    high_lim     = HIGH_LIMIT_RST;
    swing_min    = MIN_SWING_RST;
    holdoff_len  = HOLDOFF_RST;
    pk_trk       = 0;
    tr_trk       = TROUGH_TRACK_CM <<< TRACK_FRACTION_BITS;
    since_pk     = 0;
    since_tr     = 0;
    since_br     = 0;
    br_len       = 0;
    hold_cnt     = 0;
    last_pk      = PEAK_SHOWN_RST;
    pk_disp      = PEAK_SHOWN_RST;
    last_tr      = TROUGH_SHOWN_RST;
    tr_disp      = TROUGH_SHOWN_RST;
    inhale       = 1'b0;
    armed        = 1'b0;
    latch_kind   = ALARM_CLEAR;
    latch_lvl    = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening with alarms held off for good (holdoff at full scale)
    apply_setup(ATTACK_RST, RELEASE_RST, NO_CYCLE_RST, LOW_LIMIT_RST,
                HIGH_LIMIT_RST, MIN_SWING_RST, SAT_MAX);
    @(negedge clk_i);
    foreach (opening_seq[i]) sample_queue.push_back(opening_seq[i]);
    settle_idle();

    // Flat line with zero coefficients: trackers follow the sample exactly,
    // so the since counters keep climbing with no attack, and the holdoff
    // at full scale still never arms. A few breaths then end a long period.
    quiet = 1'b1;
    apply_setup(0, 0, NO_CYCLE_RST, LOW_LIMIT_RST, HIGH_LIMIT_RST,
                MIN_SWING_RST, SAT_MAX);
    @(negedge clk_i);
    repeat (FLAT_RUN) sample_queue.push_back(16'sd1280);
    queue_breathing(20, 0);
    settle_idle();
    quiet = 1'b0;

    // Short holdoff: alarms arm on the next sample, reset coefficients
    apply_setup(ATTACK_RST, RELEASE_RST, NO_CYCLE_RST, LOW_LIMIT_RST,
                HIGH_LIMIT_RST, MIN_SWING_RST, 20);
    @(negedge clk_i);
    queue_breathing(300, 3);
    settle_idle();

    // Lower rails; holdoff write after arming has no effect
    apply_setup(SAT_MAX, SAT_MAX, 1, -32768, 32767, 0, 0);
    @(negedge clk_i);
    queue_breathing(200, 5);
    settle_idle();

    // Upper rails, no idling on either side
    quiet = 1'b1;
    apply_setup($urandom_range(0, 65535), $urandom_range(60000, 65535), SAT_MAX,
                32767, -32768, SAT_MAX, SAT_MAX);
    @(negedge clk_i);
    queue_breathing(200, 5);
    settle_idle();
    quiet = 1'b0;

    // Fully random register set, short stall limit to see breath caps
    apply_setup($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(1, 200), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535));
    @(negedge clk_i);
    queue_breathing(250, 10);
    settle_idle();

    // Faster trackers with limits inside the breathing range
    apply_setup(50000, 64000, 60, 512, 5000, 256, 500);
    @(negedge clk_i);
    queue_breathing(250, 2);
    settle_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: watchdog expired, %0d samples queued, %0d results outstanding",
             $time, sample_queue.size(), monitor_outlook.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
